>>> src/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

  // width of the stretch counter and of the compared timeout
  localparam int TIMEOUT_BITS = 20;

  localparam int HALF_W     = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  localparam logic [HALF_W-1:0]       HALF_RST    = HALF_W'(10);
  localparam logic [TIMEOUT_BITS-1:0] STRETCH_RST = TIMEOUT_BITS'(100000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_PERIOD     = 1'b0,
    CFG_STRETCH_TIMEOUT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [HALF_W-1:0]       half_period_ticks;
    logic [TIMEOUT_BITS-1:0] stretch_timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       scl_level;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       stretch_timed_out;
  } res_t;

endpackage

>>> src/i2cm_cfg.sv
`timescale 1ns / 1ps

module i2cm_cfg
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_RST;
      cfg_r.stretch_timeout   <= STRETCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HALF_PERIOD:     cfg_r.half_period_ticks <= cfg_data[HALF_W-1:0];
        CFG_STRETCH_TIMEOUT: cfg_r.stretch_timeout   <= cfg_data[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/i2cm_step.sv
`timescale 1ns / 1ps

module i2cm_step
  import i2cm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_RS1  = 5'd1,
    PH_RS2  = 5'd2,
    PH_RS3  = 5'd3,
    PH_ST1  = 5'd4,
    PH_ST2  = 5'd5,
    PH_SP1  = 5'd6,
    PH_SP2  = 5'd7,
    PH_SP3  = 5'd8,
    PH_SP4  = 5'd9,
    PH_SP5  = 5'd10,
    PH_WB1  = 5'd11,
    PH_WB2  = 5'd12,
    PH_WB3  = 5'd13,
    PH_RB1  = 5'd14,
    PH_RB2  = 5'd15,
    PH_RB3  = 5'd16
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  phase_t                  phase_r, phase_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [3:0]              bit_r, bit_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [HALF_W-1:0]       dly_r, dly_nxt;
  logic [TIMEOUT_BITS-1:0] str_r, str_nxt;
  logic                    started_r, started_nxt;
  logic                    nack_r, nack_nxt;
  logic                    scl_pl_r, scl_pl_nxt;
  logic                    sda_pl_r, sda_pl_nxt;
  logic [7:0]              rx_r, rx_nxt;
  logic                    ack_r, ack_nxt;
  logic                    tmo_r, tmo_nxt;
  logic                    done_nxt;

  // per-tick helpers
  logic                    dly_end;
  logic [TIMEOUT_BITS-1:0] str_inc;
  logic                    str_expired;
  logic                    go;
  phase_t                  tgt;
  logic                    nb;
  logic                    wb_bit;

  assign dly_end     = (dly_r <= HALF_W'(1));
  assign str_inc     = str_r + TIMEOUT_BITS'(1);
  assign str_expired = (str_inc >= cfg.stretch_timeout);

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    dly_nxt     = dly_r;
    str_nxt     = str_r;
    started_nxt = started_r;
    nack_nxt    = nack_r;
    scl_pl_nxt  = scl_pl_r;
    sda_pl_nxt  = sda_pl_r;
    rx_nxt      = rx_r;
    ack_nxt     = ack_r;
    tmo_nxt     = tmo_r;
    done_nxt    = 1'b0;
    go          = 1'b0;
    tgt         = PH_IDLE;
    nb          = 1'b0;
    wb_bit      = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (item.opcode == OP_START || item.opcode == OP_STOP ||
            item.opcode == OP_WRITE || item.opcode == OP_READ) begin
          tmo_nxt = 1'b0;
          bit_nxt = 4'd0;
          go      = 1'b1;
          priority if (item.opcode == OP_START) begin
            kind_nxt = KIND_NONE;
            tgt      = started_r ? PH_RS1 : PH_ST1;
          end else if (item.opcode == OP_STOP) begin
            kind_nxt = KIND_NONE;
            tgt      = PH_SP1;
          end else if (item.opcode == OP_WRITE) begin
            kind_nxt  = KIND_WRITE;
            shift_nxt = item.tx_byte;
            tgt       = PH_WB1;
          end else begin
            kind_nxt  = KIND_READ;
            shift_nxt = 8'd0;
            nack_nxt  = item.send_nack;
            tgt       = PH_RB1;
          end
        end
      end
      // plain delay steps
      PH_RS1, PH_RS3, PH_ST1, PH_ST2, PH_SP1, PH_SP3, PH_SP4, PH_SP5,
      PH_WB1, PH_WB2, PH_RB1, PH_RB3: begin
        dly_nxt = dly_end ? '0 : dly_r - HALF_W'(1);
        if (dly_end) begin
          unique case (phase_r)
            PH_RS1: begin go = 1'b1; tgt = PH_RS2; end
            PH_RS3: begin go = 1'b1; tgt = PH_ST1; end
            PH_ST1: begin go = 1'b1; tgt = PH_ST2; end
            PH_ST2: begin
              started_nxt = 1'b1;
              phase_nxt   = PH_IDLE;
              done_nxt    = 1'b1;
            end
            PH_SP1: begin go = 1'b1; tgt = PH_SP2; end
            PH_SP3: begin go = 1'b1; tgt = PH_SP4; end
            PH_SP4: begin go = 1'b1; tgt = PH_SP5; end
            PH_SP5: begin
              started_nxt = 1'b0;
              phase_nxt   = PH_IDLE;
              done_nxt    = 1'b1;
            end
            PH_WB1: begin go = 1'b1; tgt = PH_WB2; end
            PH_WB2: begin go = 1'b1; tgt = PH_WB3; end
            PH_RB1: begin go = 1'b1; tgt = PH_RB2; end
            default: begin
              // end of a sampled bit slot
              if (kind_r == KIND_READ && bit_r < 4'd8) begin
                shift_nxt = {shift_r[6:0], item.sda_level};
              end else begin
                ack_nxt = ~item.sda_level;
              end
              scl_pl_nxt = 1'b1;
              nb         = 1'b1;
            end
          endcase
        end
      end
      // waits for scl release, bounded by the stretch timeout
      PH_RS2, PH_SP2, PH_WB3, PH_RB2: begin
        if (!item.scl_level) begin
          str_nxt = str_inc;
          if (str_expired) begin
            tmo_nxt = 1'b1;
          end
        end
        if (item.scl_level || str_expired) begin
          unique case (phase_r)
            PH_RS2: begin go = 1'b1; tgt = PH_RS3; end
            PH_SP2: begin go = 1'b1; tgt = PH_SP3; end
            PH_RB2: begin go = 1'b1; tgt = PH_RB3; end
            default: begin
              scl_pl_nxt = 1'b1;
              sda_pl_nxt = 1'b0;
              nb         = 1'b1;
            end
          endcase
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    // advance to the next bit slot, or finish the byte
    if (nb) begin
      bit_nxt = bit_r + 4'd1;
      if (bit_nxt < 4'd8) begin
        go  = 1'b1;
        tgt = (kind_r == KIND_WRITE) ? PH_WB1 : PH_RB1;
      end else if (bit_nxt == 4'd8) begin
        go  = 1'b1;
        tgt = (kind_r == KIND_WRITE) ? PH_RB1 : PH_WB1;
      end else begin
        if (kind_r == KIND_READ) begin
          rx_nxt = shift_nxt;
        end
        kind_nxt  = KIND_NONE;
        phase_nxt = PH_IDLE;
        done_nxt  = 1'b1;
      end
    end

    // pin changes and counter loads on step entry
    if (go) begin
      phase_nxt = tgt;
      unique case (tgt)
        PH_RS1: begin sda_pl_nxt = 1'b0; dly_nxt = cfg.half_period_ticks; end
        PH_RS2: begin scl_pl_nxt = 1'b0; str_nxt = '0; end
        PH_ST1: begin sda_pl_nxt = 1'b1; dly_nxt = cfg.half_period_ticks; end
        PH_ST2: begin scl_pl_nxt = 1'b1; dly_nxt = cfg.half_period_ticks; end
        PH_SP1: begin sda_pl_nxt = 1'b1; dly_nxt = cfg.half_period_ticks; end
        PH_SP2: begin scl_pl_nxt = 1'b0; str_nxt = '0; end
        PH_SP4: begin sda_pl_nxt = 1'b0; dly_nxt = cfg.half_period_ticks; end
        PH_WB1: begin
          if (kind_nxt == KIND_WRITE && bit_nxt < 4'd8) begin
            wb_bit    = shift_nxt[7];
            shift_nxt = {shift_nxt[6:0], 1'b0};
          end else begin
            wb_bit = nack_nxt;
          end
          sda_pl_nxt = ~wb_bit;
          dly_nxt    = cfg.half_period_ticks;
        end
        PH_WB2: begin scl_pl_nxt = 1'b0; dly_nxt = cfg.half_period_ticks; end
        PH_WB3: str_nxt = '0;
        PH_RB1: begin sda_pl_nxt = 1'b0; dly_nxt = cfg.half_period_ticks; end
        PH_RB2: begin scl_pl_nxt = 1'b0; str_nxt = '0; end
        default: dly_nxt = cfg.half_period_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      kind_r    <= KIND_NONE;
      bit_r     <= '0;
      shift_r   <= '0;
      dly_r     <= '0;
      str_r     <= '0;
      started_r <= 1'b0;
      nack_r    <= 1'b0;
      scl_pl_r  <= 1'b0;
      sda_pl_r  <= 1'b0;
      rx_r      <= '0;
      ack_r     <= 1'b0;
      tmo_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      dly_r     <= dly_nxt;
      str_r     <= str_nxt;
      started_r <= started_nxt;
      nack_r    <= nack_nxt;
      scl_pl_r  <= scl_pl_nxt;
      sda_pl_r  <= sda_pl_nxt;
      rx_r      <= rx_nxt;
      ack_r     <= ack_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

  always_comb begin
    res.scl_pull_low      = scl_pl_nxt;
    res.sda_pull_low      = sda_pl_nxt;
    res.busy_res          = (phase_nxt != PH_IDLE);
    res.done_res          = done_nxt;
    res.rx_byte           = rx_nxt;
    res.ack_seen          = ack_nxt;
    res.stretch_timed_out = tmo_nxt;
  end

endmodule

>>> src/i2c_master_byte_engine.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   opcode, tx_byte, send_nack, scl_level, sda_level
// out_      output     out_valid/out_stall scl/sda pull, busy, done, rx_byte, ack, timeout
// cfg_      input      cfg_we              cfg_index, cfg_data (write only)
//
// one tick transfer is taken every clock cycle while in_stall is low; each produces exactly one result transfer
// a tick passes through the input register, then the step logic into the result register
// the bus state machine advances once per tick as it leaves the input register
// rst_n is synchronous, active low; it restores both config registers to their defaults
// a stall on the result side holds the result register and then backs up the input register

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_opcode,
  input  logic [7:0]            in_tx_byte,
  input  logic                  in_send_nack,
  input  logic                  in_scl_level,
  input  logic                  in_sda_level,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl_pull_low,
  output logic                  out_sda_pull_low,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [7:0]            out_rx_byte,
  output logic                  out_ack_seen,
  output logic                  out_stretch_timed_out,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r;
  res_t  step_res;
  res_t  out_res_r;
  logic  out_valid_r;
  logic  adv;
  logic  fire;
  logic  in_take;

  // result register free, or being emptied this cycle
  assign adv      = ~out_valid_r | ~out_stall;
  assign fire     = s1_valid_r & adv;
  assign in_stall = s1_valid_r & ~adv;
  assign in_take  = in_valid & ~in_stall;

  i2cm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode    <= in_opcode;
      s1_item_r.tx_byte   <= in_tx_byte;
      s1_item_r.send_nack <= in_send_nack;
      s1_item_r.scl_level <= in_scl_level;
      s1_item_r.sda_level <= in_sda_level;
    end
  end

  // bus sequencer, one tick per transfer
  i2cm_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_scl_pull_low      = out_res_r.scl_pull_low;
  assign out_sda_pull_low      = out_res_r.sda_pull_low;
  assign out_busy_res          = out_res_r.busy_res;
  assign out_done_res          = out_res_r.done_res;
  assign out_rx_byte           = out_res_r.rx_byte;
  assign out_ack_seen          = out_res_r.ack_seen;
  assign out_stretch_timed_out = out_res_r.stretch_timed_out;

  // a completing tick always leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done_res |-> !out_res_r.busy_res)
    else $error("done result reports busy");

  // an accepted tick is held in the input register
  a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted tick lost");

  // a tick that leaves the input register lands in the result register
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("stepped tick produced no result");

endmodule
